FILE: rtl/core/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// shared concurrent assertion macros for the title sanitiser core
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold on every rising clock edge outside reset
`define ASSERT_CLK(label, clk, rstn, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) \
        else $error(msg);

// antecedent implies consequent on the same edge, outside reset
`define ASSERT_IMP(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

`endif

FILE: rtl/core/utcs_pkg.sv
// ----------------------------------------------------------------------------
// utcs_pkg
// types, constants and the codepoint remap table of the title sanitiser
// ----------------------------------------------------------------------------
package utcs_pkg;

    localparam int unsigned BYTE_W = 8;
    localparam int unsigned CP_W   = 21;
    localparam int unsigned LEN_W  = 16;
    localparam int unsigned MAP_N  = 3;   // most bytes one codepoint maps to
    localparam int unsigned BND_N  = 4;   // most results one request causes

    localparam logic [LEN_W-1:0] CAPACITY_RST = 16'd256;
    localparam logic [LEN_W:0]   CAP_MARGIN   = 17'd4;

    // codepoints with a special mapping, and the bounds of the passed-through ranges
    localparam logic [CP_W-1:0] CP_LSQUO  = 21'h02018;
    localparam logic [CP_W-1:0] CP_RSQUO  = 21'h02019;
    localparam logic [CP_W-1:0] CP_LDQUO  = 21'h0201C;
    localparam logic [CP_W-1:0] CP_RDQUO  = 21'h0201D;
    localparam logic [CP_W-1:0] CP_ENDASH = 21'h02013;
    localparam logic [CP_W-1:0] CP_EMDASH = 21'h02014;
    localparam logic [CP_W-1:0] CP_MINUS  = 21'h02212;
    localparam logic [CP_W-1:0] CP_ELLIP  = 21'h02026;
    localparam logic [CP_W-1:0] CP_BULLET = 21'h02022;
    localparam logic [CP_W-1:0] CP_RARROW = 21'h02192;
    localparam logic [CP_W-1:0] CP_LARROW = 21'h02190;
    localparam logic [CP_W-1:0] CP_COPY   = 21'h000A9;
    localparam logic [CP_W-1:0] CP_REG    = 21'h000AE;
    localparam logic [CP_W-1:0] CP_ASCII_LO = 21'h00020;
    localparam logic [CP_W-1:0] CP_ASCII_HI = 21'h0007E;
    localparam logic [CP_W-1:0] CP_LAT_LO   = 21'h000A0;
    localparam logic [CP_W-1:0] CP_LAT_HI   = 21'h000FE;

    // output characters
    localparam logic [BYTE_W-1:0] CH_SPACE = 8'h20;
    localparam logic [BYTE_W-1:0] CH_APOS  = 8'h27;
    localparam logic [BYTE_W-1:0] CH_QUOTE = 8'h22;
    localparam logic [BYTE_W-1:0] CH_DASH  = 8'h2D;
    localparam logic [BYTE_W-1:0] CH_DOT   = 8'h2E;
    localparam logic [BYTE_W-1:0] CH_STAR  = 8'h2A;
    localparam logic [BYTE_W-1:0] CH_GT    = 8'h3E;
    localparam logic [BYTE_W-1:0] CH_LT    = 8'h3C;

    typedef struct packed {
        logic [1:0]                    n;
        logic [MAP_N-1:0][BYTE_W-1:0]  b;
    } cp_map_t;

    typedef struct packed {
        logic    fin;    // end of title
        cp_map_t map;
    } dec_t;

    typedef struct packed {
        logic                          fin;
        logic [2:0]                    cnt;
        logic [BND_N-1:0][BYTE_W-1:0]  b;
        logic [LEN_W-1:0]              len;
    } bundle_t;

    function automatic cp_map_t remap(input logic [CP_W-1:0] cp);
        cp_map_t m;
        m = '0;
        if (cp >= CP_ASCII_LO && cp <= CP_ASCII_HI) begin
            m.n    = 2'd1;
            m.b[0] = cp[BYTE_W-1:0];
        end else if (cp >= CP_LAT_LO && cp <= CP_LAT_HI) begin
            if (cp != CP_COPY && cp != CP_REG) begin
                m.n    = 2'd1;
                m.b[0] = cp[BYTE_W-1:0];
            end
        end else begin
            case (cp) inside
                CP_LSQUO, CP_RSQUO: begin
                    m.n = 2'd1; m.b[0] = CH_APOS;
                end
                CP_LDQUO, CP_RDQUO: begin
                    m.n = 2'd1; m.b[0] = CH_QUOTE;
                end
                CP_ENDASH, CP_EMDASH, CP_MINUS: begin
                    m.n = 2'd1; m.b[0] = CH_DASH;
                end
                CP_ELLIP: begin
                    m.n = 2'd3; m.b = {CH_DOT, CH_DOT, CH_DOT};
                end
                CP_BULLET: begin
                    m.n = 2'd1; m.b[0] = CH_STAR;
                end
                CP_RARROW: begin
                    m.n = 2'd1; m.b[0] = CH_GT;
                end
                CP_LARROW: begin
                    m.n = 2'd1; m.b[0] = CH_LT;
                end
                default: m = '0;
            endcase
        end
        return m;
    endfunction

endpackage

FILE: rtl/core/utf8_to_cp1252_title_sanitizer.sv
// the first result of a request is registered and on m_tdata in the cycle after it is accepted
// throughput: one request per cycle while each causes at most one result and m_tready is high
// a request causing k results holds the result register until all k are taken (k up to 4)
// ready is low while the result register holds a group whose last beat is not taken
// reset (aresetn low, synchronous) clears title state and sets capacity to 256
// ----------------------------------------------------------------------------
// utf8_to_cp1252_title_sanitizer
// utf-8 title to cp1252 transcoder with space trimming and length report
// ----------------------------------------------------------------------------
module utf8_to_cp1252_title_sanitizer (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          cfg_valid,
    output logic          cfg_ready,
    input  logic [15:0]   cfg_data,     // output_capacity
    input  logic          s_tvalid,
    output logic          s_tready,
    input  logic [7:0]    s_tdata,      // [7:0] in_byte
    input  logic [0:0]    s_tuser,      // [0] string_end
    output logic          m_tvalid,
    input  logic          m_tready,
    output logic [23:0]   m_tdata,      // [7:0] out_byte, [23:8] title_length
    output logic [0:0]    m_tuser,      // [0] title_done
    output logic          m_tlast       // last_of_run
);

    utcs_pkg::dec_t    dec;
    utcs_pkg::bundle_t bnd;
    logic              take;
    logic              load;
    logic              free;

    assign cfg_ready = 1'b1;
    assign s_tready  = free;
    assign take      = s_tvalid && free;

    utcs_decode u_decode (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_data  (cfg_data),
        .take      (take),
        .in_byte   (s_tdata),
        .in_end    (s_tuser[0]),
        .dec       (dec)
    );

    utcs_trim u_trim (
        .aclk    (aclk),
        .aresetn (aresetn),
        .take    (take),
        .dec     (dec),
        .bnd     (bnd),
        .load    (load)
    );

    utcs_out u_out (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .load     (load),
        .bnd      (bnd),
        .free     (free),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

endmodule

FILE: rtl/core/utcs_decode.sv
// ----------------------------------------------------------------------------
// utcs_decode
// utf-8 sequence decoder, capacity limit and codepoint remap
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module utcs_decode (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          cfg_valid,
    input  logic [utcs_pkg::LEN_W-1:0]    cfg_data,
    input  logic                          take,
    input  logic [utcs_pkg::BYTE_W-1:0]   in_byte,
    input  logic                          in_end,
    output utcs_pkg::dec_t                dec
);

    logic [utcs_pkg::LEN_W-1:0] cap_reg;
    logic [1:0]                 need_reg,  need_next;
    logic [utcs_pkg::CP_W-1:0]  acc_reg,   acc_next;
    logic [utcs_pkg::LEN_W-1:0] pre_reg,   pre_next;
    logic                       full_reg,  full_next;

    logic                       emit;
    logic [utcs_pkg::CP_W-1:0]  cp_sel;
    logic [utcs_pkg::CP_W-1:0]  acc_shift;
    logic                       is_cont;

    assign is_cont   = (in_byte[7:6] == 2'b10);
    assign acc_shift = {acc_reg[utcs_pkg::CP_W-7:0], in_byte[5:0]};

    always_comb begin
        need_next = need_reg;
        acc_next  = acc_reg;
        full_next = full_reg;
        emit      = 1'b0;
        cp_sel    = {{(utcs_pkg::CP_W-utcs_pkg::BYTE_W){1'b0}}, in_byte};
        dec       = '0;

        if (in_end) begin
            dec.fin   = 1'b1;
            need_next = '0;
            acc_next  = '0;
            full_next = 1'b0;
        end else if (!full_reg) begin
            if (need_reg != 2'd0 && is_cont) begin
                acc_next  = acc_shift;
                need_next = need_reg - 2'd1;
                cp_sel    = acc_shift;
                emit      = (need_reg == 2'd1);
            end else begin
                // lead byte; a broken sequence restarts with this byte as a lead byte
                if (need_reg != 2'd0) begin
                    need_next = '0;
                    acc_next  = '0;
                end
                if (({1'b0, pre_reg} + utcs_pkg::CAP_MARGIN) >= {1'b0, cap_reg}) begin
                    full_next = 1'b1;
                end else if (!in_byte[7]) begin
                    emit = 1'b1;
                end else if (in_byte[7:5] == 3'b110) begin
                    acc_next  = {16'd0, in_byte[4:0]};
                    need_next = 2'd1;
                end else if (in_byte[7:4] == 4'b1110) begin
                    acc_next  = {17'd0, in_byte[3:0]};
                    need_next = 2'd2;
                end else if (in_byte[7:3] == 5'b11110) begin
                    acc_next  = {18'd0, in_byte[2:0]};
                    need_next = 2'd3;
                end
            end
        end

        if (emit) begin
            dec.map = utcs_pkg::remap(cp_sel);
        end
        pre_next = in_end ? '0 : pre_reg + {14'd0, dec.map.n};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cap_reg  <= utcs_pkg::CAPACITY_RST;
            need_reg <= '0;
            acc_reg  <= '0;
            pre_reg  <= '0;
            full_reg <= 1'b0;
        end else begin
            if (cfg_valid) begin
                cap_reg <= cfg_data;
            end
            if (take) begin
                need_reg <= need_next;
                acc_reg  <= acc_next;
                pre_reg  <= pre_next;
                full_reg <= full_next;
            end
        end
    end

    // decoding only stops between sequences
    `ASSERT_IMP(a_full_no_partial, aclk, aresetn, full_reg, need_reg == 2'd0,
        "capacity stop with a partial sequence pending")

endmodule

FILE: rtl/core/utcs_trim.sv
// ----------------------------------------------------------------------------
// utcs_trim
// space trimming and collapsing, title length count
// ----------------------------------------------------------------------------
module utcs_trim (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                take,
    input  utcs_pkg::dec_t      dec,
    output utcs_pkg::bundle_t   bnd,
    output logic                load
);

    logic                       seen_reg,  seen_next;
    logic                       space_reg, space_next;
    logic [utcs_pkg::LEN_W-1:0] emit_reg,  emit_next;
    logic                       space_only;

    assign space_only = (dec.map.n == 2'd1) && (dec.map.b[0] == utcs_pkg::CH_SPACE);

    always_comb begin
        seen_next  = seen_reg;
        space_next = space_reg;
        emit_next  = emit_reg;
        bnd        = '0;

        if (dec.fin) begin
            bnd.fin    = 1'b1;
            bnd.cnt    = 3'd1;
            bnd.len    = emit_reg;
            seen_next  = 1'b0;
            space_next = 1'b0;
            emit_next  = '0;
        end else if (space_only) begin
            // hold the space until a non-space follows
            if (seen_reg) begin
                space_next = 1'b1;
            end
        end else if (dec.map.n != 2'd0) begin
            if (space_reg) begin
                bnd.b   = {dec.map.b, utcs_pkg::CH_SPACE};
                bnd.cnt = {1'b0, dec.map.n} + 3'd1;
            end else begin
                bnd.b   = {utcs_pkg::BYTE_W'(0), dec.map.b};
                bnd.cnt = {1'b0, dec.map.n};
            end
            emit_next  = emit_reg + {13'd0, bnd.cnt};
            seen_next  = 1'b1;
            space_next = 1'b0;
        end
    end

    assign load = take && (bnd.cnt != 3'd0);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            seen_reg  <= 1'b0;
            space_reg <= 1'b0;
            emit_reg  <= '0;
        end else if (take) begin
            seen_reg  <= seen_next;
            space_reg <= space_next;
            emit_reg  <= emit_next;
        end
    end

endmodule

FILE: rtl/core/utcs_out.sv
// ----------------------------------------------------------------------------
// utcs_out
// result register, serialises up to four bytes per request
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module utcs_out (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                load,
    input  utcs_pkg::bundle_t   bnd,
    output logic                free,
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [23:0]         m_tdata,
    output logic [0:0]          m_tuser,
    output logic                m_tlast
);

    logic              valid_reg;
    utcs_pkg::bundle_t bnd_reg;
    logic [1:0]        idx_reg;
    logic              last_beat;
    logic [2:0]        last_idx;

    assign last_idx  = bnd_reg.cnt - 3'd1;
    assign last_beat = (idx_reg == last_idx[1:0]);
    assign free      = !valid_reg || (m_tready && last_beat);

    assign m_tvalid  = valid_reg;
    assign m_tdata   = {bnd_reg.len, bnd_reg.b[idx_reg]};
    assign m_tuser   = bnd_reg.fin;
    assign m_tlast   = last_beat;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
            idx_reg   <= '0;
        end else if (load) begin
            valid_reg <= 1'b1;
            idx_reg   <= '0;
        end else if (valid_reg && m_tready) begin
            if (last_beat) begin
                valid_reg <= 1'b0;
            end else begin
                idx_reg <= idx_reg + 2'd1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            bnd_reg <= bnd;
        end
    end

    `ASSERT_IMP(a_done_shape, aclk, aresetn, valid_reg && bnd_reg.fin,
        m_tlast && (m_tdata[7:0] == 8'd0), "end result not a lone zero byte")
    `ASSERT_IMP(a_idx_range, aclk, aresetn, valid_reg,
        ({1'b0, idx_reg} < bnd_reg.cnt) && (bnd_reg.cnt != 3'd0), "beat index past count")
    `ASSERT_IMP(a_len_zero, aclk, aresetn, valid_reg && !bnd_reg.fin,
        m_tdata[23:8] == 16'd0, "length set on a byte result")

endmodule
